@@ rtl/sfps_pkg.sv @@
package sfps_pkg;

    localparam int MAX_CHUNK = 8;

    // input item codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_RESP  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_PAGE_LOG2 = 3'd0;
    localparam logic [2:0] REG_READ_OP   = 3'd1;
    localparam logic [2:0] REG_PROG_OP   = 3'd2;
    localparam logic [2:0] REG_WEN_OP    = 3'd3;
    localparam logic [2:0] REG_STAT_OP   = 3'd4;
    localparam logic [2:0] REG_BUSY_MASK = 3'd5;
    localparam logic [2:0] REG_POLL_LIM  = 3'd6;

    localparam logic [1:0] ADDR_LEN_3 = 2'd3;
    localparam logic [3:0] PAGE_LOG2_MAX = 4'd12;

    typedef enum logic [1:0] {
        KIND_TXN   = 2'd0,
        KIND_RBYTE = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ,
        PH_GATHER,
        PH_POLL
    } t_phase;

    // final result of a plan
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_READ,
        TAIL_STATUS,
        TAIL_DONE
    } t_tail;

    typedef enum logic [1:0] {
        EM_BYTES,
        EM_WEN,
        EM_PROG,
        EM_TAIL
    } t_emit;

    typedef struct packed {
        logic [3:0]  page_log2;
        logic [7:0]  read_op;
        logic [7:0]  prog_op;
        logic [7:0]  wen_op;
        logic [7:0]  stat_op;
        logic [7:0]  busy_mask;
        logic [31:0] poll_limit;
    } t_cfg;

    // Results caused by one input item: read bytes, optional
    // write-enable + program pair, then one tail result.
    typedef struct packed {
        logic [3:0]  rb_cnt;
        logic [63:0] data;
        logic        wr_pair;
        t_tail       tail;
        logic        err;
        logic [23:0] addr;
        logic [3:0]  len;
    } t_plan;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  opcode;
        logic [23:0] addr;
        logic [1:0]  abytes;
        logic [3:0]  dbytes;
        logic        is_read;
        logic [63:0] tx_data;
        logic [7:0]  read_byte;
        logic        err;
        logic        last;
    } t_result;

endpackage

@@ rtl/sfps_ctrl.sv @@
module sfps_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfps_pkg::t_cfg       i_cfg,
    input  logic                 i_accept,
    input  logic [1:0]           i_cmd,
    input  logic                 i_op_is_write,
    input  logic [23:0]          i_start_address,
    input  logic [24:0]          i_byte_count,
    input  logic [7:0]           i_data_byte,
    input  logic [63:0]          i_response_data,
    output sfps_pkg::t_plan      o_plan
);
    import sfps_pkg::*;

    t_phase      r_phase,       n_phase;
    logic [23:0] r_cur_address, n_cur_address;
    logic [24:0] r_remaining,   n_remaining;
    logic [3:0]  r_chunk_len,   n_chunk_len;
    logic [3:0]  r_chunk_fill,  n_chunk_fill;
    logic [63:0] r_chunk_data,  n_chunk_data;
    logic [31:0] r_polls_left,  n_polls_left;

    logic [23:0] w_adv_addr;
    logic [24:0] w_adv_rem;
    logic [3:0]  w_fill_inc;
    logic [63:0] w_data_ins;

    function automatic logic [3:0] f_rd_len(input logic [24:0] rem);
        return (rem < 25'(MAX_CHUNK)) ? rem[3:0] : 4'(MAX_CHUNK);
    endfunction

    // chunk length capped by count, page end and chunk size
    function automatic logic [3:0] f_wr_len(input logic [23:0] addr,
                                            input logic [24:0] rem,
                                            input logic [3:0]  lg_in);
        logic [3:0]  lg;
        logic [12:0] psize;
        logic [12:0] page_left;
        logic [3:0]  m;
        lg        = (lg_in > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : lg_in;
        psize     = 13'd1 << lg;
        page_left = psize - (addr[12:0] & (psize - 13'd1));
        m         = f_rd_len(rem);
        return (page_left < 13'(m)) ? page_left[3:0] : m;
    endfunction

    assign w_adv_addr = r_cur_address + 24'(r_chunk_len);
    assign w_adv_rem  = r_remaining - 25'(r_chunk_len);
    assign w_fill_inc = r_chunk_fill + 4'd1;
    assign w_data_ins = r_chunk_data |
                        (64'(i_data_byte) << {r_chunk_fill[2:0], 3'b000});

    always_comb begin
        n_phase       = r_phase;
        n_cur_address = r_cur_address;
        n_remaining   = r_remaining;
        n_chunk_len   = r_chunk_len;
        n_chunk_fill  = r_chunk_fill;
        n_chunk_data  = r_chunk_data;
        n_polls_left  = r_polls_left;
        o_plan        = '0;
        o_plan.tail   = TAIL_NONE;

        unique case (i_cmd)
            CMD_START: begin
                n_cur_address = i_start_address;
                n_remaining   = i_byte_count;
                if (i_byte_count == '0) begin
                    o_plan.tail = TAIL_DONE;
                    n_phase     = PH_IDLE;
                end else if (i_op_is_write) begin
                    n_chunk_len  = f_wr_len(i_start_address, i_byte_count,
                                            i_cfg.page_log2);
                    n_chunk_fill = '0;
                    n_chunk_data = '0;
                    n_phase      = PH_GATHER;
                end else begin
                    n_chunk_len = f_rd_len(i_byte_count);
                    o_plan.tail = TAIL_READ;
                    o_plan.addr = i_start_address;
                    o_plan.len  = n_chunk_len;
                    n_phase     = PH_READ;
                end
            end
            CMD_DATA: begin
                if (r_phase == PH_GATHER) begin
                    n_chunk_data = w_data_ins;
                    n_chunk_fill = w_fill_inc;
                    if (w_fill_inc >= r_chunk_len) begin
                        o_plan.wr_pair = 1'b1;
                        o_plan.addr    = r_cur_address;
                        o_plan.len     = r_chunk_len;
                        o_plan.data    = w_data_ins;
                        if (i_cfg.poll_limit == '0) begin
                            o_plan.tail = TAIL_DONE;
                            o_plan.err  = 1'b1;
                            n_phase     = PH_IDLE;
                        end else begin
                            n_polls_left = i_cfg.poll_limit - 32'd1;
                            o_plan.tail  = TAIL_STATUS;
                            n_phase      = PH_POLL;
                        end
                    end
                end
            end
            CMD_RESP: begin
                if (r_phase == PH_READ) begin
                    o_plan.rb_cnt = r_chunk_len;
                    o_plan.data   = i_response_data;
                    n_cur_address = w_adv_addr;
                    n_remaining   = w_adv_rem;
                    if (w_adv_rem == '0) begin
                        o_plan.tail = TAIL_DONE;
                        n_phase     = PH_IDLE;
                    end else begin
                        n_chunk_len = f_rd_len(w_adv_rem);
                        o_plan.tail = TAIL_READ;
                        o_plan.addr = w_adv_addr;
                        o_plan.len  = n_chunk_len;
                    end
                end else if (r_phase == PH_POLL) begin
                    if ((i_response_data[7:0] & i_cfg.busy_mask) == '0) begin
                        n_cur_address = w_adv_addr;
                        n_remaining   = w_adv_rem;
                        if (w_adv_rem == '0) begin
                            o_plan.tail = TAIL_DONE;
                            n_phase     = PH_IDLE;
                        end else begin
                            n_chunk_len  = f_wr_len(w_adv_addr, w_adv_rem,
                                                    i_cfg.page_log2);
                            n_chunk_fill = '0;
                            n_chunk_data = '0;
                            n_phase      = PH_GATHER;
                        end
                    end else if (r_polls_left == '0) begin
                        o_plan.tail = TAIL_DONE;
                        o_plan.err  = 1'b1;
                        n_phase     = PH_IDLE;
                    end else begin
                        n_polls_left = r_polls_left - 32'd1;
                        o_plan.tail  = TAIL_STATUS;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_cur_address <= '0;
            r_remaining   <= '0;
            r_chunk_len   <= '0;
            r_chunk_fill  <= '0;
            r_chunk_data  <= '0;
            r_polls_left  <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_cur_address <= n_cur_address;
            r_remaining   <= n_remaining;
            r_chunk_len   <= n_chunk_len;
            r_chunk_fill  <= n_chunk_fill;
            r_chunk_data  <= n_chunk_data;
            r_polls_left  <= n_polls_left;
        end
    end

endmodule

@@ rtl/sfps_emit.sv @@
module sfps_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfps_pkg::t_cfg       i_cfg,
    input  logic                 i_plan_load,
    input  sfps_pkg::t_plan      i_plan,
    output logic                 o_plan_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sfps_pkg::t_result    o_res
);
    import sfps_pkg::*;

    t_plan   r_plan;
    logic    r_pv,    n_pv;
    t_emit   r_state, n_state;
    logic [3:0] r_bidx, n_bidx;
    t_result r_out;
    logic    r_ov;
    t_result w_cur;
    logic    w_load;
    logic    w_step;
    logic [3:0] w_bidx_inc;

    assign w_load      = !r_ov || i_ready;
    assign w_step      = r_pv && w_load;
    assign w_bidx_inc  = r_bidx + 4'd1;
    assign o_plan_free = !r_pv || (r_state == EM_TAIL && w_load);
    assign o_valid     = r_ov;
    assign o_res       = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        n_bidx  = r_bidx;
        n_pv    = r_pv;
        if (w_step) begin
            unique case (r_state)
                EM_BYTES: begin
                    n_bidx = w_bidx_inc;
                    if (w_bidx_inc == r_plan.rb_cnt) begin
                        n_state = r_plan.wr_pair ? EM_WEN : EM_TAIL;
                    end
                end
                EM_WEN:  n_state = EM_PROG;
                EM_PROG: n_state = EM_TAIL;
                EM_TAIL: n_pv    = 1'b0;
                default: n_state = EM_TAIL;
            endcase
        end
        if (i_plan_load) begin
            n_pv   = 1'b1;
            n_bidx = '0;
            if (i_plan.rb_cnt != '0) begin
                n_state = EM_BYTES;
            end else if (i_plan.wr_pair) begin
                n_state = EM_WEN;
            end else begin
                n_state = EM_TAIL;
            end
        end
    end

    // current result
    always_comb begin
        w_cur      = '0;
        w_cur.kind = KIND_TXN;
        w_cur.last = (r_state == EM_TAIL);
        unique case (r_state)
            EM_BYTES: begin
                w_cur.kind      = KIND_RBYTE;
                w_cur.read_byte = 8'(r_plan.data >> {r_bidx[2:0], 3'b000});
            end
            EM_WEN: begin
                w_cur.opcode = i_cfg.wen_op;
            end
            EM_PROG: begin
                w_cur.opcode  = i_cfg.prog_op;
                w_cur.addr    = r_plan.addr;
                w_cur.abytes  = ADDR_LEN_3;
                w_cur.dbytes  = r_plan.len;
                w_cur.tx_data = r_plan.data;
            end
            EM_TAIL: begin
                unique case (r_plan.tail)
                    TAIL_READ: begin
                        w_cur.opcode  = i_cfg.read_op;
                        w_cur.addr    = r_plan.addr;
                        w_cur.abytes  = ADDR_LEN_3;
                        w_cur.dbytes  = r_plan.len;
                        w_cur.is_read = 1'b1;
                    end
                    TAIL_STATUS: begin
                        w_cur.opcode  = i_cfg.stat_op;
                        w_cur.dbytes  = 4'd1;
                        w_cur.is_read = 1'b1;
                    end
                    TAIL_DONE: begin
                        w_cur.kind = KIND_DONE;
                        w_cur.err  = r_plan.err;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_state <= EM_TAIL;
            r_bidx  <= '0;
        end else begin
            r_pv    <= n_pv;
            r_state <= n_state;
            r_bidx  <= n_bidx;
            if (w_load) begin
                r_ov <= r_pv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_plan_load) begin
            r_plan <= i_plan;
        end
        if (w_step) begin
            r_out <= w_cur;
        end
    end

endmodule

@@ rtl/spi_flash_program_read_sequencer_core.sv @@
// Channel   | Direction | Handshake                    | Payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser cmd, tdata start/data/response
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser kind, tdata txn fields, tlast
// cfg       | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// An item is decoded in the cycle it is accepted: sequencer state updates at
// once and the results it causes (0 to 9) go to a plan register. The plan is
// drained into the output register at one result per cycle while the output
// register is not stalled, so an item with results holds the input until its
// last result moves out. The next item is accepted in the cycle the last
// result of the plan moves out, so a stalled result register holds the input off.
// Reset is synchronous: state idles and control and config registers take their defaults.
module spi_flash_program_read_sequencer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,

    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [0] op_is_write, [24:1] start_address, [49:25] byte_count,
    // [57:50] data_byte, [121:58] response_data, [127:122] zero
    input  logic [127:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]    s_axis_tuser,

    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [7:0] flash_opcode, [31:8] flash_address, [33:32] address_bytes,
    // [37:34] data_bytes, [38] is_read, [102:39] tx_data,
    // [110:103] read_byte, [111] error
    output logic [111:0]  m_axis_tdata,
    // [1:0] kind
    output logic [1:0]    m_axis_tuser,
    output logic          m_axis_tlast,

    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import sfps_pkg::*;

    t_cfg    r_cfg;
    t_plan   w_plan;
    t_result w_res;
    logic    w_accept;
    logic    w_plan_free;
    logic    w_plan_load;

    // config registers: always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.page_log2  <= 4'd8;
            r_cfg.read_op    <= 8'd3;
            r_cfg.prog_op    <= 8'd2;
            r_cfg.wen_op     <= 8'd6;
            r_cfg.stat_op    <= 8'd5;
            r_cfg.busy_mask  <= 8'd1;
            r_cfg.poll_limit <= 32'd100000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PAGE_LOG2: r_cfg.page_log2  <= i_cfg_data[3:0];
                REG_READ_OP:   r_cfg.read_op    <= i_cfg_data[7:0];
                REG_PROG_OP:   r_cfg.prog_op    <= i_cfg_data[7:0];
                REG_WEN_OP:    r_cfg.wen_op     <= i_cfg_data[7:0];
                REG_STAT_OP:   r_cfg.stat_op    <= i_cfg_data[7:0];
                REG_BUSY_MASK: r_cfg.busy_mask  <= i_cfg_data[7:0];
                REG_POLL_LIM:  r_cfg.poll_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = w_plan_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // items that cause no result never occupy the plan register
    assign w_plan_load   = w_accept && (w_plan.tail != TAIL_NONE);

    sfps_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_accept        (w_accept),
        .i_cmd           (s_axis_tuser),
        .i_op_is_write   (s_axis_tdata[0]),
        .i_start_address (s_axis_tdata[24:1]),
        .i_byte_count    (s_axis_tdata[49:25]),
        .i_data_byte     (s_axis_tdata[57:50]),
        .i_response_data (s_axis_tdata[121:58]),
        .o_plan          (w_plan)
    );

    sfps_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_plan_load (w_plan_load),
        .i_plan      (w_plan),
        .o_plan_free (w_plan_free),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;
    assign m_axis_tdata = {w_res.err, w_res.read_byte, w_res.tx_data, w_res.is_read,
                           w_res.dbytes, w_res.abytes, w_res.addr, w_res.opcode};

endmodule

@@ rtl/sfps_checker.sv @@
module sfps_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [111:0]  m_axis_tdata,
    input  logic [1:0]    m_axis_tuser,
    input  logic          m_axis_tlast
);
    import sfps_pkg::*;

    // stalled result holds its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // done always closes the results of its item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_DONE |-> m_axis_tlast)
        else $error("done without last");

    // read bytes are never marked last, so a transaction or done follows them
    a_byte_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_RBYTE |-> !m_axis_tlast)
        else $error("read byte marked last");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind spi_flash_program_read_sequencer_core sfps_checker u_sfps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
